### rtl/core/psl_pkg.sv
// ---------------------------------------------------------------------------
// psl_pkg
// Shared types and constants of the pixel shadow lift pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

	// curve select codes
	localparam logic CURVE_PARABOLA = 1'b0;
	localparam logic CURVE_TRIPLE   = 1'b1;

	// number of color lanes
	localparam int unsigned LANES = 3;
	localparam int unsigned LANE_R = 0;
	localparam int unsigned LANE_G = 1;
	localparam int unsigned LANE_B = 2;

	// reciprocal multipliers for division by constants
	localparam logic [10:0] RECIP3   = 11'd683;     // /3   -> >> 11
	localparam logic [11:0] RECIP6   = 12'd2731;    // /6   -> >> 14
	localparam logic [15:0] RECIP255 = 16'd32897;   // /255 -> >> 23

	localparam logic [7:0] CHAN_MAX  = 8'd255;
	localparam logic [7:0] LIFT_KNEE = 8'd128;

	// source pixel as it travels down the pipe
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pix_t;

	// gray and target gray attached to a pixel
	typedef struct packed {
		pix_t       pix;
		logic [7:0] gray;
		logic [7:0] tgt;
	} gray_item_t;

	// scaled channels attached to a pixel
	typedef struct packed {
		pix_t       pix;
		logic [7:0] red_sc;
		logic [7:0] green_sc;
		logic [7:0] blue_sc;
	} scl_item_t;

endpackage

`default_nettype wire

### rtl/core/psl_if.sv
// ---------------------------------------------------------------------------
// psl_if
// Valid/ready channels for source and lifted pixels.
// ---------------------------------------------------------------------------
`default_nettype none

interface psl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] alpha_in;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic       last_in;

	modport source (output valid, alpha_in, red_in, green_in, blue_in, last_in,
		input ready);
	modport sink (input valid, alpha_in, red_in, green_in, blue_in, last_in,
		output ready);
endinterface

interface psl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] alpha_out;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       last_out;

	modport source (output valid, alpha_out, red_out, green_out, blue_out, last_out,
		input ready);
	modport sink (input valid, alpha_out, red_out, green_out, blue_out, last_out,
		output ready);
endinterface

`default_nettype wire

### rtl/core/psl_gray.sv
// ---------------------------------------------------------------------------
// psl_gray
// Stages 1-2: gray mean of R, G, B and the target gray from the curve.
// ---------------------------------------------------------------------------
`default_nettype none

module psl_gray import psl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       curve_mode,
	input  wire logic       v_in,
	input  wire pix_t       d_in,
	output logic            rdy_in,
	output logic            v_out,
	output gray_item_t      d_out,
	input  wire logic       rdy_out
);

	logic        v_s1, v_s2;
	logic        en_s1, en_s2;
	pix_t        pix_s1;
	logic [7:0]  gray_s1;
	gray_item_t  item_s2;

	logic [9:0]  sum3;
	logic [20:0] sum3_x;
	logic [7:0]  knee_gap;
	logic [15:0] knee_gap_sq;
	logic [7:0]  lift;
	logic [9:0]  triple;
	logic [7:0]  tgt;

	// stage enables: a stage loads when empty or when it drains
	assign en_s2  = !v_s2 || rdy_out;
	assign en_s1  = !v_s1 || en_s2;
	assign rdy_in = en_s1;

	// stage 1: gray = (r+g+b)/3 by reciprocal multiply
	always_comb begin
		sum3   = {2'b00, d_in.red} + {2'b00, d_in.green} + {2'b00, d_in.blue};
		sum3_x = {11'd0, sum3} * {10'd0, RECIP3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= v_in;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pix_s1  <= d_in;
			gray_s1 <= sum3_x[18:11];
		end
	end

	// stage 2: target gray from the selected curve
	always_comb begin
		knee_gap    = LIFT_KNEE - gray_s1;
		knee_gap_sq = knee_gap * knee_gap;
		lift        = LIFT_KNEE - knee_gap_sq[14:7];
		triple      = {2'b00, gray_s1} + {1'b0, gray_s1, 1'b0};
		if (curve_mode == CURVE_TRIPLE) begin
			tgt = (triple > {2'b00, CHAN_MAX}) ? CHAN_MAX : triple[7:0];
		end else begin
			tgt = (gray_s1 > LIFT_KNEE) ? gray_s1 : lift;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2.pix  <= pix_s1;
			item_s2.gray <= gray_s1;
			item_s2.tgt  <= tgt;
		end
	end

	assign v_out = v_s2;
	assign d_out = item_s2;

`ifndef SYNTH
	// both curves only ever lift the gray level
	a_tgt_lifts: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (item_s2.tgt >= item_s2.gray))
		else $error("target gray below source gray");
`endif

endmodule

`default_nettype wire

### rtl/core/psl_div.sv
// ---------------------------------------------------------------------------
// psl_div
// Stages 3-5: per channel c*target/gray (c itself when gray is 0), saturated
// at 255, by a two-stage restoring divider (four quotient bits per stage).
// ---------------------------------------------------------------------------
`default_nettype none

module psl_div import psl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       v_in,
	input  wire gray_item_t d_in,
	output logic            rdy_in,
	output logic            v_out,
	output scl_item_t       d_out,
	input  wire logic       rdy_out
);

	logic v_s3, v_s4, v_s5;
	logic en_s3, en_s4, en_s5;

	pix_t                    pix_s3, pix_s4, pix_s5;
	logic [7:0]              gray_s3, gray_s4;
	logic [LANES-1:0][15:0]  prod_s3;
	logic [LANES-1:0][7:0]   rem_s4;
	logic [LANES-1:0][3:0]   lo_s4;
	logic [LANES-1:0][3:0]   qhi_s4;
	logic [LANES-1:0]        sat_s4;
	logic [LANES-1:0][7:0]   scl_s5;

	logic [LANES-1:0][7:0]   chan_in, chan_s4;
	logic [LANES-1:0][7:0]   rem_a;
	logic [LANES-1:0][3:0]   q_a;
	logic [LANES-1:0]        sat_a;
	logic [LANES-1:0][7:0]   scl_b;

	assign en_s5  = !v_s5 || rdy_out;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign rdy_in = en_s3;

	assign chan_in[LANE_R] = d_in.pix.red;
	assign chan_in[LANE_G] = d_in.pix.green;
	assign chan_in[LANE_B] = d_in.pix.blue;
	assign chan_s4[LANE_R] = pix_s4.red;
	assign chan_s4[LANE_G] = pix_s4.green;
	assign chan_s4[LANE_B] = pix_s4.blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= v_in;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// stage 3: numerators c * target
	always_ff @(posedge clk) begin
		if (en_s3) begin
			pix_s3  <= d_in.pix;
			gray_s3 <= d_in.gray;
			for (int i = 0; i < LANES; i++) begin
				prod_s3[i] <= chan_in[i] * d_in.tgt;
			end
		end
	end

	// stage 4: saturation test and quotient bits 7..4
	always_comb begin
		logic [8:0] trial;
		logic [7:0] rem;
		for (int i = 0; i < LANES; i++) begin
			sat_a[i] = (prod_s3[i][15:8] >= gray_s3);
			rem      = prod_s3[i][15:8];
			for (int k = 7; k >= 4; k--) begin
				trial = {rem, prod_s3[i][k]};
				if (trial >= {1'b0, gray_s3}) begin
					trial        = trial - {1'b0, gray_s3};
					q_a[i][k-4]  = 1'b1;
				end else begin
					q_a[i][k-4]  = 1'b0;
				end
				rem = trial[7:0];
			end
			rem_a[i] = rem;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			pix_s4  <= pix_s3;
			gray_s4 <= gray_s3;
			rem_s4  <= rem_a;
			qhi_s4  <= q_a;
			sat_s4  <= sat_a;
			for (int i = 0; i < LANES; i++) begin
				lo_s4[i] <= prod_s3[i][3:0];
			end
		end
	end

	// stage 5: quotient bits 3..0, then saturate or bypass on black gray
	always_comb begin
		logic [8:0] trial;
		logic [7:0] rem;
		logic [3:0] qlo;
		for (int i = 0; i < LANES; i++) begin
			rem = rem_s4[i];
			for (int k = 3; k >= 0; k--) begin
				trial = {rem, lo_s4[i][k]};
				if (trial >= {1'b0, gray_s4}) begin
					trial  = trial - {1'b0, gray_s4};
					qlo[k] = 1'b1;
				end else begin
					qlo[k] = 1'b0;
				end
				rem = trial[7:0];
			end
			if (gray_s4 == 8'd0) begin
				scl_b[i] = chan_s4[i];
			end else if (sat_s4[i]) begin
				scl_b[i] = CHAN_MAX;
			end else begin
				scl_b[i] = {qhi_s4[i], qlo};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			pix_s5 <= pix_s4;
			scl_s5 <= scl_b;
		end
	end

	assign v_out          = v_s5;
	assign d_out.pix      = pix_s5;
	assign d_out.red_sc   = scl_s5[LANE_R];
	assign d_out.green_sc = scl_s5[LANE_G];
	assign d_out.blue_sc  = scl_s5[LANE_B];

`ifndef SYNTH
	// partial remainder stays below the divisor in every unsaturated lane
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && (gray_s4 != 8'd0)) |->
			((sat_s4[LANE_R] || (rem_s4[LANE_R] < gray_s4)) &&
			 (sat_s4[LANE_G] || (rem_s4[LANE_G] < gray_s4)) &&
			 (sat_s4[LANE_B] || (rem_s4[LANE_B] < gray_s4))))
		else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

### rtl/core/psl_blend.sv
// ---------------------------------------------------------------------------
// psl_blend
// Stages 6-8: blend weight from the six channel mean, weighted mix of source
// and scaled channels, and the final divide by 255.
// ---------------------------------------------------------------------------
`default_nettype none

module psl_blend import psl_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      v_in,
	input  wire scl_item_t d_in,
	output logic           rdy_in,
	output logic           v_out,
	output pix_t           d_out,
	input  wire logic      rdy_out
);

	logic v_s6, v_s7, v_s8;
	logic en_s6, en_s7, en_s8;

	scl_item_t               item_s6;
	logic [7:0]              m_s6;
	logic [10:0]             sum6_s6;
	pix_t                    pix_s7, pix_s8;
	logic [LANES-1:0][15:0]  mix_s7;
	logic [LANES-1:0][7:0]   out_s8;

	logic [10:0]             sum6;
	logic [22:0]             sum6_x;
	logic [LANES-1:0][7:0]   src_s6, sc_s6;
	logic [7:0]              m_inv;
	logic [LANES-1:0][16:0]  mix_c;
	logic [LANES-1:0][31:0]  div_c;

	assign en_s8  = !v_s8 || rdy_out;
	assign en_s7  = !v_s7 || en_s8;
	assign en_s6  = !v_s6 || en_s7;
	assign rdy_in = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s6) begin
				v_s6 <= v_in;
			end
			if (en_s7) begin
				v_s7 <= v_s6;
			end
			if (en_s8) begin
				v_s8 <= v_s7;
			end
		end
	end

	// stage 6: weight m = (sum of six channels)/6
	always_comb begin
		sum6 = {3'b000, d_in.pix.red} + {3'b000, d_in.pix.green} +
			{3'b000, d_in.pix.blue} + {3'b000, d_in.red_sc} +
			{3'b000, d_in.green_sc} + {3'b000, d_in.blue_sc};
		sum6_x = {12'd0, sum6} * {11'd0, RECIP6};
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			item_s6 <= d_in;
			m_s6    <= sum6_x[21:14];
			sum6_s6 <= sum6;
		end
	end

	// stage 7: src*m + scaled*(255-m)
	assign src_s6[LANE_R] = item_s6.pix.red;
	assign src_s6[LANE_G] = item_s6.pix.green;
	assign src_s6[LANE_B] = item_s6.pix.blue;
	assign sc_s6[LANE_R]  = item_s6.red_sc;
	assign sc_s6[LANE_G]  = item_s6.green_sc;
	assign sc_s6[LANE_B]  = item_s6.blue_sc;
	assign m_inv          = CHAN_MAX - m_s6;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mix_c[i] = ({9'd0, src_s6[i]} * {9'd0, m_s6}) +
				({9'd0, sc_s6[i]} * {9'd0, m_inv});
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			pix_s7 <= item_s6.pix;
			for (int i = 0; i < LANES; i++) begin
				mix_s7[i] <= mix_c[i][15:0];
			end
		end
	end

	// stage 8: divide by 255 via reciprocal multiply
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			div_c[i] = {16'd0, mix_s7[i]} * {16'd0, RECIP255};
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			pix_s8 <= pix_s7;
			for (int i = 0; i < LANES; i++) begin
				out_s8[i] <= div_c[i][30:23];
			end
		end
	end

	assign v_out       = v_s8;
	assign d_out.alpha = pix_s8.alpha;
	assign d_out.red   = out_s8[LANE_R];
	assign d_out.green = out_s8[LANE_G];
	assign d_out.blue  = out_s8[LANE_B];
	assign d_out.last  = pix_s8.last;

`ifndef SYNTH
	// weight is the truncated mean of the six channels
	a_weight_mean: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (({3'b000, m_s6} * 11'd6) <= sum6_s6) &&
			((sum6_s6 - ({3'b000, m_s6} * 11'd6)) < 11'd6))
		else $error("blend weight is not the six channel mean");
`endif

endmodule

`default_nettype wire

### rtl/core/pixel_shadow_lift_top.sv
// Pipeline: 8 register stages; a request accepted at the input passes through
// all of them in order before it is offered on the output and can leave.
// Throughput: one pixel per clock if not stalled; the stage chain (gray,
// curve, three divider stages, weight, mix, divide by 255) is fully pipelined.
// Empty stages fill while the output is stalled; a stalled stage holds.
// Reset (arst_n low) clears all stage valid bits and sets curve_mode to 0.
// ---------------------------------------------------------------------------
// pixel_shadow_lift_top
// Per-pixel shadow lift of an ARGB stream with a selectable lift curve.
// ---------------------------------------------------------------------------
`default_nettype none

module pixel_shadow_lift_top import psl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_wr_en,
	input  wire logic  cfg_wr_data,
	psl_in_if.sink     pixel,
	psl_out_if.source  lifted
);

	logic        curve_mode_q;
	pix_t        pix_in;
	logic        g_v, g_rdy;
	gray_item_t  g_d;
	logic        s_v, s_rdy;
	scl_item_t   s_d;
	pix_t        pix_res;

	// curve select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= CURVE_PARABOLA;
		end else if (cfg_wr_en) begin
			curve_mode_q <= cfg_wr_data;
		end
	end

	assign pix_in.alpha = pixel.alpha_in;
	assign pix_in.red   = pixel.red_in;
	assign pix_in.green = pixel.green_in;
	assign pix_in.blue  = pixel.blue_in;
	assign pix_in.last  = pixel.last_in;

	psl_gray u_gray (
		.clk        (clk),
		.arst_n     (arst_n),
		.curve_mode (curve_mode_q),
		.v_in       (pixel.valid),
		.d_in       (pix_in),
		.rdy_in     (pixel.ready),
		.v_out      (g_v),
		.d_out      (g_d),
		.rdy_out    (g_rdy)
	);

	psl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_in    (g_v),
		.d_in    (g_d),
		.rdy_in  (g_rdy),
		.v_out   (s_v),
		.d_out   (s_d),
		.rdy_out (s_rdy)
	);

	psl_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_in    (s_v),
		.d_in    (s_d),
		.rdy_in  (s_rdy),
		.v_out   (lifted.valid),
		.d_out   (pix_res),
		.rdy_out (lifted.ready)
	);

	assign lifted.alpha_out = pix_res.alpha;
	assign lifted.red_out   = pix_res.red;
	assign lifted.green_out = pix_res.green;
	assign lifted.blue_out  = pix_res.blue;
	assign lifted.last_out  = pix_res.last;

endmodule

`default_nettype wire
